FILE: rtl/vas_pkg.sv
// ----------------------------------------------------------------------------
// Valve actuator supervisor package
// Shared types, command bit positions, mode codes and reset constants.
// ----------------------------------------------------------------------------
package vas_pkg;

    // Bit positions in the pending command latch.
    localparam int unsigned PEND_OPEN   = 0;
    localparam int unsigned PEND_CLOSE  = 1;
    localparam int unsigned PEND_AUTO   = 2;
    localparam int unsigned PEND_RESET  = 3;
    localparam int unsigned PEND_MANUAL = 4;
    localparam int unsigned PEND_REMOTE = 5;
    localparam int unsigned PEND_W      = 6;

    localparam logic [7:0] WATCHDOG_RESET    = 8'd50;
    localparam logic [7:0] WAIT_RELOAD_RESET = 8'd50;

    typedef enum logic [1:0] {
        MODE_AUTO   = 2'd0,
        MODE_MANUAL = 2'd1,
        MODE_REMOTE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CFG_PRESSURE_EN = 2'd0,
        CFG_LIMIT_EN    = 2'd1,
        CFG_OC_EN       = 2'd2,
        CFG_WAIT_RELOAD = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic       pressure_check_enable;
        logic       limit_check_enable;
        logic       open_circuit_check_enable;
        logic [7:0] wait_reload;
    } cfg_t;

    typedef struct packed {
        logic [PEND_W-1:0] cmds;
        logic              force_open;
        logic              force_close;
        logic              second_tick;
        logic              pressure_in;
        logic              limit_in;
        logic              circuit_ok_in;
    } scan_t;

    typedef struct packed {
        logic              drive_open;
        logic [1:0]        mode;
        logic              pressure_fault;
        logic              open_circuit_fault;
        logic              lamp_green;
        logic              lamp_attention;
        logic [PEND_W-1:0] commands_pending;
    } status_t;

endpackage

FILE: rtl/vas_ifs.sv
// ----------------------------------------------------------------------------
// Valve actuator supervisor channel interfaces
// Scan request channel, status result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface vas_scan_if;
    logic valid;
    logic ready;
    logic cmd_open;
    logic cmd_close;
    logic cmd_auto;
    logic cmd_fault_reset;
    logic cmd_manual;
    logic cmd_remote;
    logic force_open;
    logic force_close;
    logic second_tick;
    logic pressure_in;
    logic limit_in;
    logic circuit_ok_in;

    modport source (
        output valid, cmd_open, cmd_close, cmd_auto, cmd_fault_reset, cmd_manual,
               cmd_remote, force_open, force_close, second_tick, pressure_in,
               limit_in, circuit_ok_in,
        input  ready
    );
    modport sink (
        input  valid, cmd_open, cmd_close, cmd_auto, cmd_fault_reset, cmd_manual,
               cmd_remote, force_open, force_close, second_tick, pressure_in,
               limit_in, circuit_ok_in,
        output ready
    );
endinterface

interface vas_status_if;
    logic       valid;
    logic       ready;
    logic       drive_open;
    logic [1:0] mode;
    logic       pressure_fault;
    logic       open_circuit_fault;
    logic       lamp_green;
    logic       lamp_attention;
    logic [5:0] commands_pending;

    modport source (
        output valid, drive_open, mode, pressure_fault, open_circuit_fault,
               lamp_green, lamp_attention, commands_pending,
        input  ready
    );
    modport sink (
        input  valid, drive_open, mode, pressure_fault, open_circuit_fault,
               lamp_green, lamp_attention, commands_pending,
        output ready
    );
endinterface

interface vas_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/valve_actuator_supervisor.sv
// ----------------------------------------------------------------------------
// Valve actuator supervisor
// Shutoff valve command, mode and feedback watchdog supervision.
// ----------------------------------------------------------------------------
// Each scan request is captured in an input register and then run through
// the scan core, which updates the valve state and loads the status into the
// result register. A new scan is taken every clock while no status waits, so
// the sustained rate is one request per cycle when each status is taken as
// soon as it is presented. The status is presented from the result register,
// so it passes the input register and the result register after its request.
// A waiting status holds the next scan in the input register, and while that
// scan waits no further request is taken. Configuration writes are taken
// every cycle and should be made while no scan is in flight.
module valve_actuator_supervisor (
    input  logic          clk,
    input  logic          rst_n,
    vas_scan_if.sink      scan,
    vas_status_if.source  status,
    vas_cfg_if.sink       cfg
);

    vas_pkg::cfg_t    cfg_cur;
    vas_pkg::scan_t   scan_reg;
    vas_pkg::status_t core_status;
    vas_pkg::status_t status_reg;
    logic             in_valid_reg, in_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic             advance;

    vas_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    vas_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_cur),
        .scan   (scan_reg),
        .step   (advance),
        .status (core_status)
    );

    assign advance    = in_valid_reg && (!out_valid_reg || status.ready);
    assign scan.ready = !in_valid_reg || advance;

    assign in_valid_next  = scan.valid || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !status.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (scan.ready)
                in_valid_reg <= in_valid_next;
            else
                in_valid_reg <= in_valid_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan.valid && scan.ready)
        begin
            scan_reg.cmds <= {scan.cmd_remote, scan.cmd_manual, scan.cmd_fault_reset,
                              scan.cmd_auto, scan.cmd_close, scan.cmd_open};
            scan_reg.force_open    <= scan.force_open;
            scan_reg.force_close   <= scan.force_close;
            scan_reg.second_tick   <= scan.second_tick;
            scan_reg.pressure_in   <= scan.pressure_in;
            scan_reg.limit_in      <= scan.limit_in;
            scan_reg.circuit_ok_in <= scan.circuit_ok_in;
        end
        if (advance)
            status_reg <= core_status;
    end

    assign status.valid              = out_valid_reg;
    assign status.drive_open         = status_reg.drive_open;
    assign status.mode               = status_reg.mode;
    assign status.pressure_fault     = status_reg.pressure_fault;
    assign status.open_circuit_fault = status_reg.open_circuit_fault;
    assign status.lamp_green         = status_reg.lamp_green;
    assign status.lamp_attention     = status_reg.lamp_attention;
    assign status.commands_pending   = status_reg.commands_pending;

endmodule

FILE: rtl/vas_cfg_regs.sv
// ----------------------------------------------------------------------------
// Valve actuator supervisor configuration registers
// Takes register writes from the configuration channel, one per cycle.
// ----------------------------------------------------------------------------
module vas_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    vas_cfg_if.sink       cfg,
    output vas_pkg::cfg_t cfg_out
);

    vas_pkg::cfg_t cfg_reg;
    vas_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (vas_pkg::cfg_index_t'(cfg.index))
                vas_pkg::CFG_PRESSURE_EN: cfg_next.pressure_check_enable = cfg.data[0];
                vas_pkg::CFG_LIMIT_EN:    cfg_next.limit_check_enable = cfg.data[0];
                vas_pkg::CFG_OC_EN:       cfg_next.open_circuit_check_enable = cfg.data[0];
                vas_pkg::CFG_WAIT_RELOAD: cfg_next.wait_reload = cfg.data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pressure_check_enable     <= 1'b0;
            cfg_reg.limit_check_enable        <= 1'b0;
            cfg_reg.open_circuit_check_enable <= 1'b0;
            cfg_reg.wait_reload               <= vas_pkg::WAIT_RELOAD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/vas_core.sv
// ----------------------------------------------------------------------------
// Valve actuator supervisor scan core
// Holds the valve state and computes one scan cycle's update and status.
// ----------------------------------------------------------------------------
module vas_core (
    input  logic             clk,
    input  logic             rst_n,
    input  vas_pkg::cfg_t    cfg,
    input  vas_pkg::scan_t   scan,
    input  logic             step,
    output vas_pkg::status_t status
);

    logic                      pos_reg, pos_next;
    logic                      man_reg, man_next;
    logic                      rem_reg, rem_next;
    logic                      fault_reg, fault_next;
    logic                      circ_reg, circ_next;
    logic [vas_pkg::PEND_W-1:0] pend_reg, pend_next;
    logic [7:0]                wd_reg, wd_next;

    // The two checks share one watchdog and are applied one after the other.
    always_comb
    begin
        pend_next  = pend_reg | scan.cmds;
        pos_next   = pos_reg;
        man_next   = man_reg;
        rem_next   = rem_reg;
        fault_next = fault_reg;
        wd_next    = wd_reg;

        if (scan.force_open)
            pos_next = 1'b1;
        if (scan.force_close)
            pos_next = 1'b0;

        priority if (man_reg || rem_reg)
        begin
            if (pend_next[vas_pkg::PEND_OPEN])
            begin
                pend_next[vas_pkg::PEND_OPEN] = 1'b0;
                pos_next = 1'b1;
            end
            if (pend_next[vas_pkg::PEND_CLOSE])
            begin
                pend_next[vas_pkg::PEND_CLOSE] = 1'b0;
                pos_next = 1'b0;
            end
            if (pend_next[vas_pkg::PEND_AUTO])
            begin
                pend_next[vas_pkg::PEND_AUTO] = 1'b0;
                man_next = 1'b0;
                rem_next = 1'b0;
            end
            if (pend_next[vas_pkg::PEND_RESET])
            begin
                pend_next[vas_pkg::PEND_RESET] = 1'b0;
                fault_next = 1'b0;
                wd_next    = cfg.wait_reload;
            end
        end
        else if (pend_next[vas_pkg::PEND_MANUAL])
        begin
            pend_next[vas_pkg::PEND_MANUAL] = 1'b0;
            man_next = 1'b1;
        end
        else if (pend_next[vas_pkg::PEND_REMOTE])
        begin
            pend_next[vas_pkg::PEND_REMOTE] = 1'b0;
            rem_next = 1'b1;
        end
        else
        begin
            pend_next = pend_next;
        end

        if (cfg.pressure_check_enable)
        begin
            if (pos_next ? scan.pressure_in : !scan.pressure_in)
                wd_next = cfg.wait_reload;
            if (scan.second_tick && wd_next != 8'd0)
                wd_next = wd_next - 8'd1;
            if (wd_next == 8'd0)
                fault_next = 1'b1;
        end
        if (cfg.limit_check_enable)
        begin
            if (pos_next ? !scan.limit_in : scan.limit_in)
                wd_next = cfg.wait_reload;
            if (scan.second_tick && wd_next != 8'd0)
                wd_next = wd_next - 8'd1;
            if (wd_next == 8'd0)
                fault_next = 1'b1;
        end

        circ_next = cfg.open_circuit_check_enable ? !scan.circuit_ok_in : circ_reg;
    end

    always_comb
    begin
        status.drive_open         = pos_next;
        status.mode               = man_next ? vas_pkg::MODE_MANUAL
                                  : (rem_next ? vas_pkg::MODE_REMOTE : vas_pkg::MODE_AUTO);
        status.pressure_fault     = fault_next;
        status.open_circuit_fault = circ_next;
        status.lamp_green         = pos_next;
        status.lamp_attention     = fault_next || circ_next || man_next || rem_next;
        status.commands_pending   = pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 1'b0;
            man_reg   <= 1'b0;
            rem_reg   <= 1'b0;
            fault_reg <= 1'b0;
            circ_reg  <= 1'b0;
            pend_reg  <= '0;
            wd_reg    <= vas_pkg::WATCHDOG_RESET;
        end
        else if (step)
        begin
            pos_reg   <= pos_next;
            man_reg   <= man_next;
            rem_reg   <= rem_next;
            fault_reg <= fault_next;
            circ_reg  <= circ_next;
            pend_reg  <= pend_next;
            wd_reg    <= wd_next;
        end
    end

endmodule
